// ----- rtl/core/skb_pkg.sv -----
// ----------------------------------------------------------------------------
// skb_pkg
// Types, scan-code constants and the decode table of the key buffer.
// ----------------------------------------------------------------------------
package skb_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] scan_code;
  } req_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic [8:0] buffer_count;
    logic [2:0] lock_leds;
    logic       leds_changed;
    logic       reset_request;
  } rsp_t;

  localparam logic       REQ_SCAN    = 1'b0;
  localparam logic       REQ_POP     = 1'b1;

  localparam logic [7:0] SC_DELETE   = 8'h53;
  localparam logic [7:0] SC_CAPS     = 8'h3A;
  localparam logic [7:0] SC_NUM      = 8'h45;
  localparam logic [7:0] SC_SCROLL   = 8'h46;
  localparam logic [7:0] SC_CTRL     = 8'h1D;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_ALT      = 8'h38;
  localparam logic [7:0] SC_BREAK    = 8'h80;
  localparam logic [7:0] ROM_ROWS    = 8'd84;

  // lock bits: scroll, num, caps; modifier bits: shift, alt, ctrl
  localparam int LK_SCROLL = 0;
  localparam int LK_NUM    = 1;
  localparam int LK_CAPS   = 2;
  localparam int MD_SHIFT  = 0;
  localparam int MD_ALT    = 1;
  localparam int MD_CTRL   = 2;

  typedef logic [0:7][7:0] rom_row_t;

  function automatic rom_row_t letter(input logic [7:0] l, input logic [7:0] u,
                                      input logic [7:0] c);
    return {l, u, c, 8'h00, l, u, l, u};
  endfunction

  function automatic rom_row_t sym(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
    return {a, b, c, 8'h00, a, a, b, b};
  endfunction

  function automatic rom_row_t kpad(input logic [7:0] d);
    return {8'h00, d, 8'h00, 8'h00, d, 8'h00, d, 8'h00};
  endfunction

  // Entries wider than one byte are stored as zero: they never reach the buffer.
  function automatic rom_row_t rom_row(input logic [6:0] row);
    rom_row_t r;
    r = '0;
    case (row)
      7'd1:  r = sym(8'h1B, 8'h1B, 8'h1B);
      7'd2:  r = sym(8'h31, 8'h21, 8'h00);
      7'd3:  r = sym(8'h32, 8'h40, 8'h00);
      7'd4:  r = sym(8'h33, 8'h23, 8'h00);
      7'd5:  r = sym(8'h34, 8'h24, 8'h00);
      7'd6:  r = sym(8'h35, 8'h25, 8'h00);
      7'd7:  r = sym(8'h36, 8'h5E, 8'h1E);
      7'd8:  r = sym(8'h37, 8'h26, 8'h00);
      7'd9:  r = sym(8'h38, 8'h2A, 8'h00);
      7'd10: r = sym(8'h39, 8'h28, 8'h00);
      7'd11: r = sym(8'h30, 8'h29, 8'h00);
      7'd12: r = sym(8'h2D, 8'h5F, 8'h1F);
      7'd13: r = sym(8'h3D, 8'h2B, 8'h00);
      7'd14: r = sym(8'h08, 8'h08, 8'h7F);
      7'd15: r = sym(8'h09, 8'h00, 8'h00);
      7'd16: r = letter(8'h71, 8'h51, 8'h11);
      7'd17: r = letter(8'h77, 8'h57, 8'h17);
      7'd18: r = letter(8'h65, 8'h45, 8'h05);
      7'd19: r = letter(8'h72, 8'h52, 8'h12);
      7'd20: r = letter(8'h74, 8'h54, 8'h14);
      7'd21: r = letter(8'h79, 8'h59, 8'h19);
      7'd22: r = letter(8'h75, 8'h55, 8'h15);
      7'd23: r = letter(8'h69, 8'h49, 8'h09);
      7'd24: r = letter(8'h6F, 8'h4F, 8'h0F);
      7'd25: r = letter(8'h70, 8'h50, 8'h10);
      7'd26: r = sym(8'h5B, 8'h7B, 8'h1B);
      7'd27: r = sym(8'h5D, 8'h7D, 8'h1D);
      7'd28: r = {8'h0A, 8'h0A, 8'h0D, 8'h00, 8'h0A, 8'h0A, 8'h0D, 8'h0D};
      7'd30: r = letter(8'h61, 8'h41, 8'h01);
      7'd31: r = letter(8'h73, 8'h53, 8'h13);
      7'd32: r = letter(8'h64, 8'h44, 8'h04);
      7'd33: r = letter(8'h66, 8'h46, 8'h06);
      7'd34: r = letter(8'h67, 8'h47, 8'h07);
      7'd35: r = letter(8'h68, 8'h48, 8'h08);
      7'd36: r = letter(8'h6A, 8'h4A, 8'h0A);
      7'd37: r = letter(8'h6B, 8'h4B, 8'h0B);
      7'd38: r = letter(8'h6C, 8'h4C, 8'h0C);
      7'd39: r = sym(8'h3B, 8'h3A, 8'h00);
      7'd40: r = sym(8'h27, 8'h22, 8'h00);
      7'd41: r = sym(8'h60, 8'h7E, 8'h00);
      7'd42: r = {8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      7'd43: r = sym(8'h5C, 8'h7C, 8'h1C);
      7'd44: r = letter(8'h7A, 8'h5A, 8'h1A);
      7'd45: r = letter(8'h78, 8'h58, 8'h18);
      7'd46: r = letter(8'h63, 8'h43, 8'h03);
      7'd47: r = letter(8'h76, 8'h56, 8'h16);
      7'd48: r = letter(8'h62, 8'h42, 8'h02);
      7'd49: r = letter(8'h6E, 8'h4E, 8'h0E);
      7'd50: r = letter(8'h6D, 8'h4D, 8'h0D);
      7'd51: r = sym(8'h2C, 8'h3C, 8'h00);
      7'd52: r = sym(8'h2E, 8'h3E, 8'h00);
      7'd53: r = sym(8'h2F, 8'h3F, 8'h00);
      7'd57: r = sym(8'h20, 8'h20, 8'h20);
      7'd71: r = kpad(8'h37);
      7'd72: r = kpad(8'h38);
      7'd73: r = kpad(8'h39);
      7'd74: r = sym(8'h2D, 8'h2D, 8'h00);
      7'd75: r = kpad(8'h34);
      7'd76: r = kpad(8'h35);
      7'd77: r = kpad(8'h36);
      7'd78: r = sym(8'h2B, 8'h2B, 8'h00);
      7'd79: r = kpad(8'h31);
      7'd80: r = kpad(8'h32);
      7'd81: r = kpad(8'h33);
      7'd82: r = kpad(8'h30);
      7'd83: r = kpad(8'h2E);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/skb_ram.sv -----
// ----------------------------------------------------------------------------
// skb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/scancode_to_ascii_key_buffer.sv -----
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_buffer
// Set-1 scan code decoder with lock/modifier tracking and a character FIFO.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  req     | req_valid/req_stall | skb_pkg::req_t (req_type, scan_code)
//  rsp     | rsp_valid/rsp_stall | skb_pkg::rsp_t (one result per request)
//
// One request per cycle while req_stall is low; a result passes through the
// registered read of the key RAM and the s1 stage, then the output register.
// Flags, pointer and count update in the transfer cycle, so back-to-back
// pushes and pops need no forwarding. Reset clears all control state; the
// key RAM is not cleared. A stall on rsp holds both stages; with s1 full it stalls req.
module scancode_to_ascii_key_buffer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  skb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output skb_pkg::rsp_t rsp
);

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [2:0]       lock_flags, lock_next;
  logic [2:0]       mod_flags, mod_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  logic             s1_valid, s1_pop;
  skb_pkg::rsp_t    s1_rsp, s1_rsp_next;
  skb_pkg::rsp_t    rsp_next;

  logic             out_free, s1_move, accept;
  logic             is_pop, pop_ok, push;
  logic [7:0]       key, char_byte;
  logic [2:0]       col;
  skb_pkg::rom_row_t row;
  logic [SUM_W-1:0] wsum;
  logic [PTR_W-1:0] waddr;
  logic [7:0]       rdata;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_move   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  assign is_pop = (req.req_type == skb_pkg::REQ_POP);
  assign key    = req.scan_code;
  assign pop_ok = is_pop && (count != '0);

  always_comb begin
    lock_next = lock_flags;
    mod_next  = mod_flags;
    if (key == skb_pkg::SC_CAPS)   lock_next[skb_pkg::LK_CAPS]   = !lock_flags[skb_pkg::LK_CAPS];
    if (key == skb_pkg::SC_NUM)    lock_next[skb_pkg::LK_NUM]    = !lock_flags[skb_pkg::LK_NUM];
    if (key == skb_pkg::SC_SCROLL) lock_next[skb_pkg::LK_SCROLL] = !lock_flags[skb_pkg::LK_SCROLL];
    if (key == skb_pkg::SC_CTRL) mod_next[skb_pkg::MD_CTRL] = 1'b1;
    if (key == (skb_pkg::SC_BREAK | skb_pkg::SC_CTRL)) mod_next[skb_pkg::MD_CTRL] = 1'b0;
    if (key == skb_pkg::SC_LSHIFT || key == skb_pkg::SC_RSHIFT) begin
      mod_next[skb_pkg::MD_SHIFT] = 1'b1;
    end
    if (key == (skb_pkg::SC_BREAK | skb_pkg::SC_LSHIFT) ||
        key == (skb_pkg::SC_BREAK | skb_pkg::SC_RSHIFT)) begin
      mod_next[skb_pkg::MD_SHIFT] = 1'b0;
    end
    if (key == skb_pkg::SC_ALT) mod_next[skb_pkg::MD_ALT] = 1'b1;
    if (key == (skb_pkg::SC_BREAK | skb_pkg::SC_ALT)) mod_next[skb_pkg::MD_ALT] = 1'b0;
  end

  // Column priority uses the flags after this code's update.
  always_comb begin
    if (mod_next[skb_pkg::MD_SHIFT] && lock_next[skb_pkg::LK_CAPS]) col = 3'd6;
    else if (mod_next[skb_pkg::MD_SHIFT])                            col = 3'd1;
    else if (mod_next[skb_pkg::MD_CTRL])                             col = 3'd2;
    else if (mod_next[skb_pkg::MD_ALT])                              col = 3'd3;
    else if (lock_next[skb_pkg::LK_CAPS])                            col = 3'd5;
    else if (lock_next[skb_pkg::LK_NUM])                             col = 3'd4;
    else                                                             col = 3'd0;
  end

  assign row       = skb_pkg::rom_row(key[6:0]);
  assign char_byte = (key < skb_pkg::ROM_ROWS) ? row[col] : 8'h00;
  assign push      = !is_pop && (char_byte != 8'h00) && (count < CNT_W'(BUFFER_DEPTH));

  assign wsum  = SUM_W'(rd_ptr) + SUM_W'(count);
  assign waddr = (wsum >= SUM_W'(BUFFER_DEPTH)) ? PTR_W'(wsum - SUM_W'(BUFFER_DEPTH))
                                                 : PTR_W'(wsum);

  always_comb begin
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (pop_ok) begin
      rd_ptr_next = (rd_ptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end else if (push) begin
      count_next  = count + 1'b1;
    end
  end

  always_comb begin
    s1_rsp_next               = '0;
    s1_rsp_next.char_valid    = pop_ok;
    s1_rsp_next.buffer_count  = 9'(count_next);
    s1_rsp_next.lock_leds     = is_pop ? lock_flags : lock_next;
    s1_rsp_next.leds_changed  = !is_pop && (key == skb_pkg::SC_CAPS ||
                                key == skb_pkg::SC_NUM || key == skb_pkg::SC_SCROLL);
    s1_rsp_next.reset_request = !is_pop && (key == skb_pkg::SC_DELETE) &&
                                mod_flags[skb_pkg::MD_CTRL] && mod_flags[skb_pkg::MD_ALT];
  end

  skb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (accept && push),
    .waddr (waddr),
    .wdata (char_byte),
    .re    (accept && pop_ok),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_flags <= '0;
      mod_flags  <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else if (accept) begin
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      if (!is_pop) begin
        lock_flags <= lock_next;
        mod_flags  <= mod_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept)       s1_valid  <= 1'b1;
      else if (s1_move) s1_valid  <= 1'b0;
      if (s1_move)      rsp_valid <= 1'b1;
      else if (out_free) rsp_valid <= 1'b0;
    end
  end

  // merge the RAM read data into the staged result
  always_comb begin
    rsp_next           = s1_rsp;
    rsp_next.char_code = s1_pop ? rdata : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rsp <= s1_rsp_next;
      s1_pop <= pop_ok;
    end
    if (s1_move) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BUFFER_DEPTH))
    else $error("key buffer count past depth");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid)
    else $error("request stalled with free pipeline");

  a_pop_no_reset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.char_valid |-> !rsp.reset_request && !rsp.leds_changed)
    else $error("pop result carries scan flags");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.char_valid |-> rsp.char_code == 8'h00)
    else $error("char code without valid character");
`endif

endmodule
